@@ rtl/core/gse_pkg.sv @@
package gse_pkg;

   localparam int GSE_INDEX_BITS      = 12;
   localparam int GSE_EXP_TABLE_DEPTH = 256;

   localparam int GSE_FALLOFF_W   = 24;
   localparam int GSE_GAIN_W      = 16;
   localparam int GSE_SAMPLE_W    = 16;
   localparam int GSE_FACTOR_W    = 32;
   localparam int GSE_CSR_DATA_W  = 24;
   localparam int GSE_CSR_INDEX_W = 3;

   localparam logic signed [GSE_GAIN_W-1:0] GSE_GAIN_RESET = 16'sd256;

   // register stages inside one axis unit
   localparam int GSE_AXIS_STAGES = 7;

   typedef enum logic [GSE_CSR_INDEX_W-1:0] {
      CSR_NUM_ROWS       = 3'd0,
      CSR_NUM_COLS       = 3'd1,
      CSR_ROW_FALLOFF    = 3'd2,
      CSR_COL_FALLOFF    = 3'd3,
      CSR_AMPLITUDE_GAIN = 3'd4
   } gse_csr_type;

   typedef struct packed {
      logic [GSE_AXIS_STAGES-1:0] stage;
   } gse_adv_type;

endpackage

@@ rtl/core/gse_axis.sv @@
module gse_axis #(
   parameter int INDEX_BITS      = gse_pkg::GSE_INDEX_BITS,
   parameter int EXP_TABLE_DEPTH = gse_pkg::GSE_EXP_TABLE_DEPTH
) (
   input  logic                                 clock,
   input  gse_pkg::gse_adv_type                 adv,
   input  logic [INDEX_BITS-1:0]                index,
   input  logic [INDEX_BITS:0]                  size,
   input  logic [gse_pkg::GSE_FALLOFF_W-1:0]    falloff,
   output logic [gse_pkg::GSE_FACTOR_W-1:0]     factor
);
   import gse_pkg::*;

   localparam int MAG_W   = INDEX_BITS + 1;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int P_W     = SQ_W + GSE_FALLOFF_W;
   localparam int X_W     = 28;
   localparam int DEPTH_W = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int POS_W   = X_W + DEPTH_W;
   localparam int FRAC_W  = 24;
   localparam int ROM_W   = 33;
   localparam int DIFF_W  = 32;
   localparam int DPROD_W = DIFF_W + FRAC_W;

   localparam logic [127:0] ROM_STEP = (128'd1 << 36) / EXP_TABLE_DEPTH;

   typedef logic [ROM_W-1:0] rom_type [0:EXP_TABLE_DEPTH];

   function automatic logic [63:0] div_small(input logic [63:0] num, input logic [5:0] den);
      logic [63:0] quo;
      logic [6:0]  rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[5:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-16/D) by Taylor series, then successive powers in Q1.32
   function automatic rom_type build_rom();
      rom_type      rom;
      logic [127:0] term;
      logic [127:0] acc;
      logic [127:0] prod;
      term = 128'd1 << 32;
      acc  = 128'd1 << 32;
      for (int n = 1; n < 25; n++) begin
         prod = (term * ROM_STEP) >> 32;
         term = {64'b0, div_small(prod[63:0], 6'(n))};
         if (n[0]) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      rom[0] = 33'h1_0000_0000;
      for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
         prod   = 128'(rom[k-1]) * acc + (128'd1 << 31);
         rom[k] = prod[64:32];
      end
      return rom;
   endfunction

   localparam rom_type EXP_ROM = build_rom();

   logic signed [INDEX_BITS+1:0] h;
   logic [MAG_W-1:0]             mag_ff;
   logic [SQ_W-1:0]              sq_ff;
   logic [P_W-1:0]               p_ff;
   logic [POS_W-1:0]             pos;
   logic [DEPTH_W-1:0]           idx_ff;
   logic [FRAC_W-1:0]            frac3_ff;
   logic                         over3_ff;
   logic [ROM_W-1:0]             lo4_ff;
   logic [ROM_W-1:0]             hi4_ff;
   logic [FRAC_W-1:0]            frac4_ff;
   logic                         over4_ff;
   logic [DIFF_W-1:0]            diff;
   logic [DPROD_W-1:0]           dprod;
   logic [ROM_W-1:0]             lo5_ff;
   logic [DIFF_W-1:0]            dsh5_ff;
   logic                         over5_ff;
   logic [ROM_W-1:0]             e;
   logic [ROM_W:0]               esum;
   logic [GSE_FACTOR_W-1:0]      factor_ff;

   always_comb begin
      h     = $signed({1'b0, index, 1'b0}) - $signed({1'b0, size});
      pos   = POS_W'(p_ff[X_W+1:2]) * POS_W'(EXP_TABLE_DEPTH);
      diff  = DIFF_W'(lo4_ff - hi4_ff);
      dprod = DPROD_W'(diff) * DPROD_W'(frac4_ff);
      e     = lo5_ff - {1'b0, dsh5_ff};
      esum  = {1'b0, e} + {{ROM_W{1'b0}}, 1'b1};
   end

   always_ff @(posedge clock) begin
      if (adv.stage[0]) begin
         mag_ff <= h[INDEX_BITS+1] ? MAG_W'(-h) : MAG_W'(h);
      end
      if (adv.stage[1]) begin
         sq_ff <= SQ_W'(mag_ff) * SQ_W'(mag_ff);
      end
      if (adv.stage[2]) begin
         p_ff <= P_W'(sq_ff) * P_W'(falloff);
      end
      if (adv.stage[3]) begin
         over3_ff <= |p_ff[P_W-1:30];
         idx_ff   <= pos[X_W +: DEPTH_W];
         frac3_ff <= pos[X_W-1:4];
      end
      if (adv.stage[4]) begin
         lo4_ff   <= EXP_ROM[idx_ff];
         hi4_ff   <= EXP_ROM[DEPTH_W'(idx_ff + 1'b1)];
         frac4_ff <= frac3_ff;
         over4_ff <= over3_ff;
      end
      if (adv.stage[5]) begin
         lo5_ff   <= lo4_ff;
         dsh5_ff  <= dprod[DPROD_W-1:FRAC_W];
         over5_ff <= over4_ff;
      end
      if (adv.stage[6]) begin
         factor_ff <= over5_ff ? '0 : esum[ROM_W-1:1];
      end
   end

   assign factor = factor_ff;

endmodule

@@ rtl/core/gaussian_envelope_sample_top.sv @@
// Separable 2-D Gaussian envelope sample source.
// An accepted request beat passes the axis stages, then envelope product, envelope, magnitude and output registers.
// Throughput: one sample per cycle while rsp_stall is low; stages advance independently, bubbles collapse.
// Reset (synchronous): pipeline emptied, num_rows/num_cols = 2^INDEX_BITS,
// falloffs 0, amplitude_gain 1.0.
module gaussian_envelope_sample_top #(
   parameter int INDEX_BITS      = gse_pkg::GSE_INDEX_BITS,
   parameter int EXP_TABLE_DEPTH = gse_pkg::GSE_EXP_TABLE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [INDEX_BITS-1:0]                  req_row_index,
   input  logic [INDEX_BITS-1:0]                  req_col_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [gse_pkg::GSE_SAMPLE_W-1:0] rsp_sample_value,
   input  logic                                   csr_write_enable,
   input  logic [gse_pkg::GSE_CSR_INDEX_W-1:0]    csr_index,
   input  logic [gse_pkg::GSE_CSR_DATA_W-1:0]     csr_data
);
   import gse_pkg::*;

   localparam int SIZE_W     = INDEX_BITS + 1;
   localparam int NUM_STAGES = GSE_AXIS_STAGES + 4;
   localparam int ST_ENVP    = GSE_AXIS_STAGES;
   localparam int ST_ENV     = GSE_AXIS_STAGES + 1;
   localparam int ST_MAG     = GSE_AXIS_STAGES + 2;
   localparam int ST_OUT     = GSE_AXIS_STAGES + 3;
   localparam int ENVP_W     = 2 * GSE_FACTOR_W;
   localparam int M_W        = GSE_GAIN_W + GSE_FACTOR_W;

   logic [SIZE_W-1:0]               num_rows_ff;
   logic [SIZE_W-1:0]               num_cols_ff;
   logic [GSE_FALLOFF_W-1:0]        row_falloff_ff;
   logic [GSE_FALLOFF_W-1:0]        col_falloff_ff;
   logic signed [GSE_GAIN_W-1:0]    gain_ff;

   logic [NUM_STAGES-1:0]           valid_ff;
   logic [NUM_STAGES-1:0]           valid_in;
   logic [NUM_STAGES-1:0]           en;
   gse_adv_type                     adv;

   logic [GSE_FACTOR_W-1:0]         row_factor;
   logic [GSE_FACTOR_W-1:0]         col_factor;

   logic [ENVP_W-1:0]               envp_ff;
   logic [ENVP_W-1:0]               envp_sum;
   logic [GSE_FACTOR_W-1:0]         env_ff;
   logic [GSE_GAIN_W-1:0]           gain_mag;
   logic [M_W-1:0]                  m_ff;
   logic                            neg_ff;
   logic [M_W-1:0]                  m_sum;
   logic [GSE_SAMPLE_W:0]           r;
   logic signed [GSE_SAMPLE_W-1:0]  res;
   logic signed [GSE_SAMPLE_W-1:0]  sample_ff;

   // per-stage advance: a stage moves when empty or when its successor moves
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (en[i]) begin
            valid_in[i] = (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
      adv.stage = en[GSE_AXIS_STAGES-1:0];
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         num_rows_ff    <= {1'b1, {INDEX_BITS{1'b0}}};
         num_cols_ff    <= {1'b1, {INDEX_BITS{1'b0}}};
         row_falloff_ff <= '0;
         col_falloff_ff <= '0;
         gain_ff        <= GSE_GAIN_RESET;
      end else begin
         valid_ff <= valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_NUM_ROWS:       num_rows_ff    <= csr_data[SIZE_W-1:0];
               CSR_NUM_COLS:       num_cols_ff    <= csr_data[SIZE_W-1:0];
               CSR_ROW_FALLOFF:    row_falloff_ff <= csr_data[GSE_FALLOFF_W-1:0];
               CSR_COL_FALLOFF:    col_falloff_ff <= csr_data[GSE_FALLOFF_W-1:0];
               CSR_AMPLITUDE_GAIN: gain_ff        <= $signed(csr_data[GSE_GAIN_W-1:0]);
               default: ;
            endcase
         end
      end
   end

   gse_axis #(
      .INDEX_BITS      (INDEX_BITS),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_row_axis (
      .clock   (clock),
      .adv     (adv),
      .index   (req_row_index),
      .size    (num_rows_ff),
      .falloff (row_falloff_ff),
      .factor  (row_factor)
   );

   gse_axis #(
      .INDEX_BITS      (INDEX_BITS),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_col_axis (
      .clock   (clock),
      .adv     (adv),
      .index   (req_col_index),
      .size    (num_cols_ff),
      .falloff (col_falloff_ff),
      .factor  (col_factor)
   );

   always_comb begin
      envp_sum = envp_ff + (ENVP_W'(1) << 30);
      gain_mag = gain_ff[GSE_GAIN_W-1] ? GSE_GAIN_W'(-gain_ff) : GSE_GAIN_W'(gain_ff);
      m_sum    = m_ff + (M_W'(1) << 30);
      r        = m_sum[M_W-1:31];
      if (neg_ff) begin
         res = (r >= 17'd32768) ? 16'sh8000 : $signed(GSE_SAMPLE_W'(17'd0 - r));
      end else begin
         res = (r >= 17'd32767) ? 16'sh7fff : $signed(r[GSE_SAMPLE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_ENVP]) begin
         envp_ff <= ENVP_W'(row_factor) * ENVP_W'(col_factor);
      end
      if (en[ST_ENV]) begin
         env_ff <= envp_sum[GSE_FACTOR_W+30:31];
      end
      if (en[ST_MAG]) begin
         m_ff   <= M_W'(gain_mag) * M_W'(env_ff);
         neg_ff <= gain_ff[GSE_GAIN_W-1];
      end
      if (en[ST_OUT]) begin
         sample_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff[NUM_STAGES-1];
   assign rsp_sample_value = sample_ff;

endmodule

@@ rtl/core/gse_checker.sv @@
module gse_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [gse_pkg::GSE_SAMPLE_W-1:0] rsp_sample_value
);
   import gse_pkg::*;

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // with the result side free, a request beat is never held off
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req_stall while rsp side not stalled");

   // back-pressure only comes from a full, stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a held rsp beat");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sample_value)))
      else $error("rsp beat changed while stalled");

endmodule

bind gaussian_envelope_sample_top gse_checker u_gse_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sample_value (rsp_sample_value)
);
